// ===== sv/assert_macros.svh =====
// Assertion macros for the wait queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swq assertion failed");
`define SWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swq assertion failed");
`else
`define SWQ_ASSERT(label, clk, rst_n, prop)
`define SWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/swq_pkg.sv =====
`default_nettype none
package swq_pkg;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 4;
  localparam int TIME_W   = 64;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_SORTED_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TAIL_INSERT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAKE_TIME     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKE_COUNT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAKE_ALL      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_IN  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_QUEUED  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_I_CHK,
    ST_FN_RD,
    ST_FN_WR,
    ST_FP_RD,
    ST_FP_WR,
    ST_SELF,
    ST_R_LINK,
    ST_W_CHK,
    ST_W_FIN,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== sv/swq_ram.sv =====
`default_nettype none
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/sorted_wakeup_wait_queue_unit.sv =====
// Sorted wakeup wait queue. Entries are kept in a doubly linked list held in a
// link memory, with wakeup times in a second memory; both have registered
// reads. One request is handled at a time. A sorted insert walks from the
// head past each queued entry whose time is not later than its own; the
// walk reads one entry of both memories per cycle. A tail insert or a remove
// is done by read-modify-write passes on the neighbor links. A wake request
// pops head entries, one head entry read per cycle while the output is not
// stalled. No clearing pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"
module sorted_wakeup_wait_queue_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [swq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [swq_pkg::TIME_W-1:0]    in_time_value,
  input  logic [swq_pkg::COUNT_W-1:0]   in_wake_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swq_pkg::ID_W-1:0]      out_woken_id,
  output logic                          out_woken_valid,
  output logic [swq_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);
  import swq_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int LD = 2 * IW;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [TIME_W-1:0]   tv_r;
  logic [COUNT_W-1:0]  lim_r;

  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       tail_r, tail_nxt;
  logic                empty_r, empty_nxt;
  logic [ENTRIES-1:0]  queued_r, queued_nxt;

  logic [IW-1:0]       cur_r, cur_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IW-1:0]       pend_r, pend_nxt;

  logic                fn_en_r, fn_en_nxt;
  logic [IW-1:0]       fn_addr_r, fn_addr_nxt;
  logic [IW-1:0]       fn_val_r, fn_val_nxt;
  logic                fp_en_r, fp_en_nxt;
  logic [IW-1:0]       fp_addr_r, fp_addr_nxt;
  logic [IW-1:0]       fp_val_r, fp_val_nxt;
  logic                self_en_r, self_en_nxt;
  logic [IW-1:0]       self_next_r, self_next_nxt;
  logic [IW-1:0]       self_prev_r, self_prev_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic                out_wv_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic                t_we;
  logic [TIME_W-1:0]   t_rdata;
  logic                l_we;
  logic [IW-1:0]       l_waddr;
  logic [LD-1:0]       l_wdata;
  logic [LD-1:0]       l_rdata;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       l_next, l_prev;

  logic                emit;
  logic [ID_W-1:0]     e_id;
  logic                e_wv;
  logic [STATUS_W-1:0] e_status;
  logic                e_last;

  logic [IW-1:0]       id_idx;
  logic                id_ok, id_q, is_insert, is_wake;
  logic                le, cur_tail, pops, ofree, adv;
  logic                pred_nil, p_nil, n_nil;

  swq_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (id_idx),
    .wdata (tv_r),
    .raddr (raddr),
    .rdata (t_rdata)
  );

  swq_ram #(.WIDTH(LD), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  assign l_next    = l_rdata[LD-1:IW];
  assign l_prev    = l_rdata[IW-1:0];
  assign id_idx    = IW'(id_r);
  assign id_ok     = 32'(id_r) < 32'(ENTRIES);
  assign id_q      = id_ok && queued_r[id_idx];
  assign is_insert = (cmd_r == CMD_SORTED_INSERT) || (cmd_r == CMD_TAIL_INSERT);
  assign is_wake   = (cmd_r == CMD_WAKE_TIME) || (cmd_r == CMD_WAKE_COUNT) ||
                     (cmd_r == CMD_WAKE_ALL);
  assign le        = t_rdata <= tv_r;
  assign cur_tail  = cur_r == tail_r;
  assign ofree     = !out_valid_r || out_ready;
  assign adv       = pops && (!pend_v_r || ofree);
  assign pred_nil  = cur_r == head_r;
  assign p_nil     = id_idx == head_r;
  assign n_nil     = id_idx == tail_r;

  always_comb begin
    case (cmd_r)
      CMD_WAKE_TIME:  pops = le;
      CMD_WAKE_COUNT: pops = cnt_r < lim_r;
      default:        pops = 1'b1;
    endcase
  end

  assign in_ready        = state_r == ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_woken_id    = out_id_r;
  assign out_woken_valid = out_wv_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (is_insert) begin
          if (id_q || !id_ok) state_nxt = ST_RESP;
          else if (cmd_r == CMD_SORTED_INSERT && !empty_r) state_nxt = ST_I_CHK;
          else state_nxt = ST_FN_RD;
        end else if (cmd_r == CMD_REMOVE) begin
          state_nxt = id_q ? ST_R_LINK : ST_RESP;
        end else if (is_wake) begin
          state_nxt = empty_r ? ST_W_FIN : ST_W_CHK;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_I_CHK: begin
        if (!le || cur_tail) state_nxt = ST_FN_RD;
      end
      ST_R_LINK: state_nxt = ST_FN_RD;
      ST_FN_RD:  state_nxt = ST_FN_WR;
      ST_FN_WR:  state_nxt = ST_FP_RD;
      ST_FP_RD:  state_nxt = ST_FP_WR;
      ST_FP_WR:  state_nxt = ST_SELF;
      ST_SELF:   state_nxt = ST_RESP;
      ST_W_CHK: begin
        if (!pops || (adv && cur_tail)) state_nxt = ST_W_FIN;
      end
      ST_W_FIN: begin
        if (ofree) state_nxt = ST_IDLE;
      end
      ST_RESP: begin
        if (ofree) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    queued_nxt    = queued_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    fn_en_nxt     = fn_en_r;
    fn_addr_nxt   = fn_addr_r;
    fn_val_nxt    = fn_val_r;
    fp_en_nxt     = fp_en_r;
    fp_addr_nxt   = fp_addr_r;
    fp_val_nxt    = fp_val_r;
    self_en_nxt   = self_en_r;
    self_next_nxt = self_next_r;
    self_prev_nxt = self_prev_r;
    status_nxt    = status_r;
    t_we          = 1'b0;
    l_we          = 1'b0;
    l_waddr       = fn_addr_r;
    l_wdata       = {fn_val_r, l_prev};
    raddr         = cur_r;
    emit          = 1'b0;
    e_id          = '0;
    e_wv          = 1'b0;
    e_status      = STATUS_OK;
    e_last        = 1'b1;
    case (state_r)
      ST_DISP: begin
        status_nxt = STATUS_OK;
        fn_en_nxt  = 1'b0;
        fp_en_nxt  = 1'b0;
        self_en_nxt = 1'b0;
        if (is_insert) begin
          if (id_q || !id_ok) begin
            status_nxt = STATUS_ALREADY_IN;
          end else begin
            t_we = 1'b1;
            queued_nxt[id_idx] = 1'b1;
            if (cmd_r == CMD_SORTED_INSERT && !empty_r) begin
              raddr   = head_r;
              cur_nxt = head_r;
            end else begin
              self_en_nxt   = 1'b1;
              self_next_nxt = tail_r;
              self_prev_nxt = tail_r;
              tail_nxt      = id_idx;
              empty_nxt     = 1'b0;
              if (empty_r) begin
                head_nxt = id_idx;
              end else begin
                fn_en_nxt   = 1'b1;
                fn_addr_nxt = tail_r;
                fn_val_nxt  = id_idx;
              end
            end
          end
        end else if (cmd_r == CMD_REMOVE) begin
          if (!id_q) status_nxt = STATUS_NOT_QUEUED;
          raddr = id_idx;
        end else if (is_wake) begin
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          raddr      = head_r;
          cur_nxt    = head_r;
        end
      end
      ST_I_CHK: begin
        if (le) begin
          if (cur_tail) begin
            tail_nxt      = id_idx;
            fn_en_nxt     = 1'b1;
            fn_addr_nxt   = cur_r;
            fn_val_nxt    = id_idx;
            self_en_nxt   = 1'b1;
            self_next_nxt = cur_r;
            self_prev_nxt = cur_r;
          end else begin
            cur_nxt = l_next;
            raddr   = l_next;
          end
        end else begin
          if (pred_nil) head_nxt = id_idx;
          fn_en_nxt     = !pred_nil;
          fn_addr_nxt   = l_prev;
          fn_val_nxt    = id_idx;
          fp_en_nxt     = 1'b1;
          fp_addr_nxt   = cur_r;
          fp_val_nxt    = id_idx;
          self_en_nxt   = 1'b1;
          self_next_nxt = cur_r;
          self_prev_nxt = l_prev;
        end
      end
      ST_R_LINK: begin
        queued_nxt[id_idx] = 1'b0;
        if (p_nil && n_nil) begin
          empty_nxt = 1'b1;
        end else begin
          if (p_nil) head_nxt = l_next;
          if (n_nil) tail_nxt = l_prev;
        end
        fn_en_nxt   = !p_nil;
        fn_addr_nxt = l_prev;
        fn_val_nxt  = l_next;
        fp_en_nxt   = !n_nil;
        fp_addr_nxt = l_next;
        fp_val_nxt  = l_prev;
      end
      ST_FN_RD: begin
        raddr = fn_addr_r;
      end
      ST_FN_WR: begin
        l_we    = fn_en_r;
        l_waddr = fn_addr_r;
        l_wdata = {fn_val_r, l_prev};
      end
      ST_FP_RD: begin
        raddr = fp_addr_r;
      end
      ST_FP_WR: begin
        l_we    = fp_en_r;
        l_waddr = fp_addr_r;
        l_wdata = {l_next, fp_val_r};
      end
      ST_SELF: begin
        l_we    = self_en_r;
        l_waddr = id_idx;
        l_wdata = {self_next_r, self_prev_r};
      end
      ST_W_CHK: begin
        if (adv) begin
          emit   = pend_v_r;
          e_id   = ID_W'(pend_r);
          e_wv   = 1'b1;
          e_last = 1'b0;
          queued_nxt[cur_r] = 1'b0;
          pend_nxt   = cur_r;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + COUNT_W'(1);
          if (cur_tail) begin
            empty_nxt = 1'b1;
          end else begin
            head_nxt = l_next;
            cur_nxt  = l_next;
            raddr    = l_next;
          end
        end
      end
      ST_W_FIN: begin
        emit = ofree;
        e_id = pend_v_r ? ID_W'(pend_r) : '0;
        e_wv = pend_v_r;
      end
      ST_RESP: begin
        emit     = ofree;
        e_status = status_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      empty_r     <= 1'b1;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      empty_r  <= empty_nxt;
      queued_r <= queued_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      id_r  <= in_entry_id;
      tv_r  <= in_time_value;
      lim_r <= in_wake_count;
    end
    if (emit) begin
      out_id_r     <= e_id;
      out_wv_r     <= e_wv;
      out_status_r <= e_status;
      out_last_r   <= e_last;
    end
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    cur_r       <= cur_nxt;
    cnt_r       <= cnt_nxt;
    pend_r      <= pend_nxt;
    fn_en_r     <= fn_en_nxt;
    fn_addr_r   <= fn_addr_nxt;
    fn_val_r    <= fn_val_nxt;
    fp_en_r     <= fp_en_nxt;
    fp_addr_r   <= fp_addr_nxt;
    fp_val_r    <= fp_val_nxt;
    self_en_r   <= self_en_nxt;
    self_next_r <= self_next_nxt;
    self_prev_r <= self_prev_nxt;
    status_r    <= status_nxt;
  end

  `SWQ_ASSERT(a_emit_free, clk, rst_n, emit |-> ofree)
  `SWQ_ASSERT(a_empty_none, clk, rst_n, empty_r |-> (queued_r == '0))
  `SWQ_ASSERT(a_head_queued, clk, rst_n, !empty_r |-> queued_r[head_r])
  `SWQ_ASSERT(a_walk_nonempty, clk, rst_n, (state_r == ST_W_CHK) |-> !empty_r)
  `SWQ_ASSERT_NEXT(a_last_idle, clk, rst_n, emit && e_last, state_r == ST_IDLE)

endmodule
`default_nettype wire

// ===== tb/sv/swq_checker.sv =====
`timescale 1ns / 1ps
module swq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [swq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [swq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [swq_pkg::TIME_W-1:0]    in_time_value,
  input  logic [swq_pkg::COUNT_W-1:0]   in_wake_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swq_pkg::ID_W-1:0]      out_woken_id,
  input  logic                          out_woken_valid,
  input  logic [swq_pkg::STATUS_W-1:0]  out_status,
  input  logic                          out_last,
  output int                            fail_count,
  output int                            pending_count
);
  import swq_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [4:0] NIL = 5'h1f;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                last;
  } wake_result_t;

  wake_result_t expected_results[$];
  logic [TIME_W-1:0] wake_time [NSLOT];
  logic [4:0] next_of [NSLOT];
  logic [4:0] prev_of [NSLOT];
  logic       is_queued [NSLOT];
  logic [4:0] head_slot, tail_slot;

  assign pending_count = expected_results.size();

  function automatic wake_result_t mk(logic [ID_W-1:0] id, logic v,
                                      logic [STATUS_W-1:0] s, logic l);
    wake_result_t r;
    r.id = id; r.valid = v; r.status = s; r.last = l;
    return r;
  endfunction

  task automatic link_slot(input logic [4:0] id, input logic [4:0] succ);
    logic [4:0] pred;
    if (succ == NIL) begin
      pred = tail_slot;
      tail_slot = id;
    end else begin
      pred = prev_of[succ];
      prev_of[succ] = id;
    end
    if (pred == NIL) head_slot = id;
    else next_of[pred] = id;
    prev_of[id] = pred;
    next_of[id] = succ;
    is_queued[id] = 1'b1;
  endtask

  task automatic unlink_slot(input logic [4:0] id);
    logic [4:0] p, n;
    p = prev_of[id];
    n = next_of[id];
    if (p == NIL) head_slot = n;
    else next_of[p] = n;
    if (n == NIL) tail_slot = p;
    else prev_of[n] = p;
    prev_of[id] = NIL;
    next_of[id] = NIL;
    is_queued[id] = 1'b0;
  endtask

  task automatic predict_wakeups(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] tv,
                                 input logic [COUNT_W-1:0] cnt);
    logic [4:0] cur;
    int k;
    k = 0;
    if (cmd == CMD_SORTED_INSERT || cmd == CMD_TAIL_INSERT) begin
      if (is_queued[id]) begin
        expected_results.push_back(mk('0, 1'b0, STATUS_ALREADY_IN, 1'b1));
      end else begin
        wake_time[id] = tv;
        cur = NIL;
        if (cmd == CMD_SORTED_INSERT) begin
          cur = head_slot;
          while (cur != NIL && wake_time[cur] <= tv) cur = next_of[cur];
        end
        link_slot({1'b0, id}, cur);
        expected_results.push_back(mk('0, 1'b0, STATUS_OK, 1'b1));
      end
    end else if (cmd == CMD_REMOVE) begin
      if (!is_queued[id]) begin
        expected_results.push_back(mk('0, 1'b0, STATUS_NOT_QUEUED, 1'b1));
      end else begin
        unlink_slot({1'b0, id});
        expected_results.push_back(mk('0, 1'b0, STATUS_OK, 1'b1));
      end
    end else if (cmd == CMD_WAKE_TIME || cmd == CMD_WAKE_COUNT || cmd == CMD_WAKE_ALL) begin
      while (head_slot != NIL && k < NSLOT) begin
        cur = head_slot;
        if (cmd == CMD_WAKE_TIME && wake_time[cur] > tv) break;
        if (cmd == CMD_WAKE_COUNT && k >= cnt) break;
        unlink_slot(cur);
        expected_results.push_back(mk(cur[ID_W-1:0], 1'b1, STATUS_OK, 1'b0));
        k++;
      end
      if (k == 0) expected_results.push_back(mk('0, 1'b0, STATUS_OK, 1'b1));
      else expected_results[$].last = 1'b1;
    end else begin
      expected_results.push_back(mk('0, 1'b0, STATUS_OK, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    wake_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_results.delete();
      fail_count <= 0;
      head_slot = NIL;
      tail_slot = NIL;
      for (int i = 0; i < NSLOT; i++) begin
        next_of[i] = NIL;
        prev_of[i] = NIL;
        is_queued[i] = 1'b0;
        wake_time[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result id=%0d", out_woken_id);
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (out_woken_id !== e.id) begin
            $error("woken_id expected %0d actual %0d", e.id, out_woken_id);
            errs++;
          end
          if (out_woken_valid !== e.valid) begin
            $error("woken_valid expected %0d actual %0d", e.valid, out_woken_valid);
            errs++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errs++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (in_valid && in_ready)
        predict_wakeups(in_cmd, in_entry_id, in_time_value, in_wake_count);
    end
  end
endmodule

// ===== tb/sv/tb_sorted_wakeup_wait_queue_unit.sv =====
`timescale 1ns / 1ps
module tb_sorted_wakeup_wait_queue_unit;
  import swq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [ID_W-1:0] in_entry_id = '0;
  logic [TIME_W-1:0] in_time_value = '0;
  logic [COUNT_W-1:0] in_wake_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_woken_id;
  logic out_woken_valid;
  logic [STATUS_W-1:0] out_status;
  logic out_last;
  int fail_count;
  int pending_count;
  bit stimulus_done = 1'b0;

  sorted_wakeup_wait_queue_unit dut (.*);
  swq_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] tv, input logic [COUNT_W-1:0] cnt,
                              input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_id <= id;
    in_time_value <= tv;
    in_wake_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [TIME_W-1:0] rand_time(input int mode);
    if (mode == 0) return {$urandom, $urandom};
    return TIME_W'($urandom_range(0, 40));
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CODE_EXTRA(input int r);
    return (r & 1) ? CMD_UNDEF_B : CMD_UNDEF_A;
  endfunction

  initial begin
    logic [CMD_W-1:0] c;
    int r;
    int mode;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(CMD_WAKE_ALL, 0, 0, 0, 1'b0);
    send_request(CMD_SORTED_INSERT, 3, 64'd50, 0, 1'b0);
    send_request(CMD_SORTED_INSERT, 15, '1, 0, 1'b0);
    send_request(CMD_SORTED_INSERT, 0, 64'd0, 0, 1'b0);
    send_request(CMD_SORTED_INSERT, 7, 64'd50, 0, 1'b0);
    send_request(CMD_SORTED_INSERT, 3, 64'd1, 0, 1'b0);
    send_request(CMD_TAIL_INSERT, 9, 64'd5, 0, 1'b0);
    send_request(CMD_REMOVE, 7, 0, 0, 1'b0);
    send_request(CMD_REMOVE, 7, 0, 0, 1'b0);
    send_request(CMD_WAKE_COUNT, 0, 0, 5'd0, 1'b0);
    send_request(CMD_WAKE_COUNT, 0, 0, 5'd1, 1'b0);
    send_request(CMD_WAKE_TIME, 0, 64'd50, 0, 1'b0);
    send_request(CMD_WAKE_TIME, 0, '1, 0, 1'b0);
    for (int i = 0; i < 16; i++)
      send_request(CMD_TAIL_INSERT, i[3:0], TIME_W'(16 - i), 0, 1'b0);
    send_request(CMD_WAKE_COUNT, 0, 0, 5'd16, 1'b0);
    send_request(CMD_UNDEF_A, 0, 0, 0, 1'b0);
    send_request(CMD_UNDEF_B, 4'hf, '1, 5'h1f, 1'b0);
    for (int i = 0; i < 16; i++)
      send_request(CMD_SORTED_INSERT, i[3:0], rand_time(1), 0, 1'b0);
    send_request(CMD_WAKE_ALL, 0, 0, 0, 1'b0);
    for (int n = 0; n < 160; n++) begin
      if (n == 100) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
      end
      r = $urandom_range(0, 99);
      mode = $urandom_range(0, 3);
      if (r < 40) c = CMD_SORTED_INSERT;
      else if (r < 52) c = CMD_TAIL_INSERT;
      else if (r < 66) c = CMD_REMOVE;
      else if (r < 80) c = CMD_WAKE_TIME;
      else if (r < 90) c = CMD_WAKE_COUNT;
      else if (r < 96) c = CMD_WAKE_ALL;
      else c = CMD_CODE_EXTRA(r);
      send_request(c, ID_W'($urandom_range(0, 15)), rand_time(mode),
                   COUNT_W'($urandom_range(0, 31)), (n % 50) < 35);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    int gap;
    int k;
    k = 0;
    @(posedge clk);
    forever begin
      gap = ((k / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      k++;
    end
  end

  initial begin
    wait (stimulus_done);
    do @(posedge clk); while (pending_count != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/swq_pkg.sv
sv/swq_ram.sv
sv/sorted_wakeup_wait_queue_unit.sv
tb/sv/swq_checker.sv
tb/sv/tb_sorted_wakeup_wait_queue_unit.sv
